// ----- rtl/ipta_pkg.sv -----
// ----------------------------------------------------------------------------
// IP pool trie allocator package
// Shared widths, register indexes, result codes, sequencer states and the
// pool configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ipta_pkg;

   localparam int ADDR_W    = 32;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 9;
   localparam int PREFIX_W  = 5;
   localparam int HOST_W    = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NETWORK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX  = 2'd1;

   localparam logic [ADDR_W-1:0]   RESET_NETWORK = 32'hC0A8_0000;
   localparam logic [PREFIX_W-1:0] RESET_PREFIX  = 5'd24;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 3'd0,
      STATUS_RANGE  = 3'd1,
      STATUS_FULL   = 3'd2,
      STATUS_DOUBLE = 3'd3,
      STATUS_CONFIG = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RSV,
      ST_ROOT,
      ST_DESC,
      ST_ASC,
      ST_LEAF,
      ST_RELEASE,
      ST_RESP
   } seq_state_type;

   typedef struct packed {
      logic              ok;
      logic [HOST_W-1:0] host_bits;
      logic [ADDR_W-1:0] host_mask;
      logic [ADDR_W-1:0] network;
   } pool_cfg_type;

endpackage

`default_nettype wire

// ----- rtl/ipta_if.sv -----
// ----------------------------------------------------------------------------
// IP pool trie allocator channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipta_req_if;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [ipta_pkg::ADDR_W-1:0] address;

   modport source (output valid, output kind, output address, input ready);
   modport sink   (input valid, input kind, input address, output ready);
endinterface

interface ipta_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ipta_pkg::STATUS_W-1:0] status;
   logic [ipta_pkg::ADDR_W-1:0]   granted_address;
   logic [ipta_pkg::COUNT_W-1:0]  free_count;

   modport source (output valid, output status, output granted_address,
                   output free_count, input ready);
   modport sink   (input valid, input status, input granted_address,
                   input free_count, output ready);
endinterface

interface ipta_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ipta_pkg::CSR_IDX_W-1:0] index;
   logic [ipta_pkg::ADDR_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ipta_node_ram.sv -----
// ----------------------------------------------------------------------------
// IP pool trie allocator node memory
// One full bit per trie node, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ipta_node_ram #(
   parameter int AW = 9
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic          wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic               rd_data_ff
);

   logic mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/ipta_sequencer.sv -----
// ----------------------------------------------------------------------------
// IP pool trie allocator sequencer
// Walks the trie one level per cycle through the node memory: clear sweep,
// reserved-address walks, allocate descent and ascent, and release.
// ----------------------------------------------------------------------------
`default_nettype none

module ipta_sequencer #(
   parameter int MAX_HOST_BITS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rebuild,
   input  wire ipta_pkg::pool_cfg_type        cfg,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_kind,
   input  wire logic [ipta_pkg::ADDR_W-1:0]   req_address,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ipta_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ipta_pkg::ADDR_W-1:0]        rsp_granted,
   output logic [ipta_pkg::COUNT_W-1:0]       rsp_count,
   output logic                               mem_wr_en,
   output logic [MAX_HOST_BITS:0]             mem_wr_addr,
   output logic                               mem_wr_data,
   output logic [MAX_HOST_BITS:0]             mem_rd_addr,
   input  wire logic                          mem_rd_data
);

   import ipta_pkg::*;

   localparam int M     = MAX_HOST_BITS;
   localparam int NW    = MAX_HOST_BITS + 1;
   localparam int LV_W  = $clog2(MAX_HOST_BITS);
   localparam int CNT_W = MAX_HOST_BITS + 1;

   seq_state_type    state_ff, state_in;
   logic [NW-1:0]    node_ff, node_in;
   logic [NW-1:0]    leaf_ff, leaf_in;
   logic [LV_W-1:0]  bit_ff, bit_in;
   logic             cur_ff, cur_in;
   logic [M-1:0]     req_ff, req_in;
   logic [1:0]       rsv_ff, rsv_in;
   logic             rsv_busy_ff, rsv_busy_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type       status_ff, status_in;
   logic [ADDR_W-1:0] granted_ff, granted_in;

   logic [M-1:0]     host_mask;
   logic [LV_W-1:0]  top_bit;
   logic [M-1:0]     rsv_req;
   logic             in_pool;
   logic             reserved;
   logic [NW-1:0]    chosen;
   logic [NW-1:0]    parent;
   logic             parent_val;
   logic [CNT_W+COUNT_W-1:0] count_ext;

   assign host_mask = cfg.host_mask[M-1:0];
   assign top_bit   = LV_W'(cfg.host_bits - HOST_W'(1));
   assign in_pool   = (req_address & ~cfg.host_mask) == cfg.network;
   assign reserved  = (req_address == cfg.network) ||
                      (req_address == cfg.network + ADDR_W'(1)) ||
                      (req_address == (cfg.network | cfg.host_mask));
   assign chosen     = node_ff ^ NW'(mem_rd_data);
   assign parent     = node_ff >> 1;
   assign parent_val = cur_ff & mem_rd_data;

   always_comb begin
      case (rsv_ff)
         2'd0:    rsv_req = '0;
         2'd1:    rsv_req = M'(1);
         default: rsv_req = host_mask;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         node_ff     <= '0;
         rsv_ff      <= '0;
         rsv_busy_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         node_ff     <= node_in;
         rsv_ff      <= rsv_in;
         rsv_busy_ff <= rsv_busy_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      leaf_ff    <= leaf_in;
      bit_ff     <= bit_in;
      cur_ff     <= cur_in;
      req_ff     <= req_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   always_comb begin
      state_in    = state_ff;
      node_in     = node_ff;
      leaf_in     = leaf_ff;
      bit_in      = bit_ff;
      cur_in      = cur_ff;
      req_in      = req_ff;
      rsv_in      = rsv_ff;
      rsv_busy_in = rsv_busy_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      granted_in  = granted_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = node_ff;
      mem_wr_data = 1'b0;
      mem_rd_addr = node_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            node_in   = node_ff + NW'(1);
            if (node_ff == '1) begin
               if (cfg.ok) begin
                  count_in    = CNT_W'(1) << cfg.host_bits;
                  rsv_in      = 2'd0;
                  rsv_busy_in = 1'b1;
                  state_in    = ST_RSV;
               end else begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RSV: begin
            req_in      = rsv_req;
            mem_rd_addr = NW'({1'b1, rsv_req[top_bit]});
            node_in     = mem_rd_addr;
            bit_in      = top_bit;
            state_in    = ST_DESC;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in     = req_address[M-1:0];
               granted_in = '0;
               if (!cfg.ok) begin
                  status_in = STATUS_CONFIG;
                  state_in  = ST_RESP;
               end else if (!in_pool || (req_kind && reserved)) begin
                  status_in = STATUS_RANGE;
                  state_in  = ST_RESP;
               end else if (!req_kind) begin
                  mem_rd_addr = NW'(1);
                  state_in    = ST_ROOT;
               end else begin
                  mem_rd_addr = (NW'(1) << cfg.host_bits) |
                                NW'(req_address[M-1:0] & host_mask);
                  node_in     = mem_rd_addr;
                  state_in    = ST_LEAF;
               end
            end
         end
         ST_ROOT: begin
            if (mem_rd_data) begin
               status_in = STATUS_FULL;
               state_in  = ST_RESP;
            end else begin
               mem_rd_addr = NW'({1'b1, req_ff[top_bit]});
               node_in     = mem_rd_addr;
               bit_in      = top_bit;
               state_in    = ST_DESC;
            end
         end
         ST_DESC: begin
            if (bit_ff == '0) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = chosen;
               mem_wr_data = 1'b1;
               mem_rd_addr = chosen ^ NW'(1);
               node_in     = chosen;
               leaf_in     = chosen;
               cur_in      = 1'b1;
               state_in    = ST_ASC;
            end else begin
               mem_rd_addr = {chosen[NW-2:0], req_ff[bit_ff - LV_W'(1)]};
               node_in     = mem_rd_addr;
               bit_in      = bit_ff - LV_W'(1);
            end
         end
         ST_ASC: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = parent;
            mem_wr_data = parent_val;
            mem_rd_addr = parent ^ NW'(1);
            node_in     = parent;
            cur_in      = parent_val;
            if (parent == NW'(1)) begin
               if (count_ff != '0) begin
                  count_in = count_ff - CNT_W'(1);
               end
               if (rsv_busy_ff) begin
                  if (rsv_ff == 2'd2) begin
                     rsv_busy_in = 1'b0;
                     state_in    = ST_IDLE;
                  end else begin
                     rsv_in   = rsv_ff + 2'd1;
                     state_in = ST_RSV;
                  end
               end else begin
                  status_in  = STATUS_OK;
                  granted_in = cfg.network | ADDR_W'(leaf_ff[M-1:0] & host_mask);
                  state_in   = ST_RESP;
               end
            end
         end
         ST_LEAF: begin
            if (!mem_rd_data) begin
               status_in = STATUS_DOUBLE;
               state_in  = ST_RESP;
            end else begin
               state_in = ST_RELEASE;
            end
         end
         ST_RELEASE: begin
            mem_wr_en = 1'b1;
            node_in   = parent;
            if (node_ff == NW'(1)) begin
               count_in  = count_ff + CNT_W'(1);
               status_in = STATUS_OK;
               state_in  = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (rebuild) begin
         state_in    = ST_CLEAR;
         node_in     = '0;
         rsv_busy_in = 1'b0;
      end
   end

   assign count_ext   = (CNT_W+COUNT_W)'(count_ff);
   assign rsp_status  = status_ff;
   assign rsp_granted = granted_ff;
   assign rsp_count   = count_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/ip_pool_trie_allocator.sv -----
// ----------------------------------------------------------------------------
// IP pool trie allocator
// Address pool over a binary trie of full bits, with configuration registers.
// ----------------------------------------------------------------------------
// Usage:
// req_if carries one item: kind 0 allocates the requested address (or the
// nearest free one along the trie), kind 1 releases an address. rsp_if
// returns one item per request with status, granted address and free count.
// csr_if writes the network address (index 0) or prefix length (index 1);
// it is always ready, and a write to either one empties and rebuilds the pool.
// With h host bits, an allocate runs a root check, h descent and h ascent
// steps through the single node memory port pair; a release checks the
// leaf, then clears full bits from the leaf to the root; out-of-range and
// config-error items answer without a trie access, pool-full items after
// the root check and double-free items after the leaf check. One item is
// in flight at a time, so the next item is accepted the cycle after the response is taken.
// After reset or a write to either register the node memory is cleared
// node by node, then, if the configuration is valid, three walks reserve the
// network, server and broadcast addresses; req_if is not ready meanwhile.
// While the receiver stalls the response is held and no item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_pool_trie_allocator #(
   parameter int MAX_HOST_BITS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   ipta_req_if.sink   req_if,
   ipta_rsp_if.source rsp_if,
   ipta_csr_if.sink   csr_if
);

   import ipta_pkg::*;

   localparam int NW = MAX_HOST_BITS + 1;

   logic [ADDR_W-1:0]   network_ff;
   logic [PREFIX_W-1:0] prefix_ff;
   logic [HOST_W-1:0]   host_bits;
   logic [ADDR_W-1:0]   host_mask;
   pool_cfg_type        cfg;
   logic                csr_write;
   logic                rebuild;

   logic          mem_wr_en;
   logic [NW-1:0] mem_wr_addr;
   logic          mem_wr_data;
   logic [NW-1:0] mem_rd_addr;
   logic          mem_rd_data;

   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid && csr_if.ready;
   assign rebuild      = csr_write &&
                         (csr_if.index == CSR_NETWORK || csr_if.index == CSR_PREFIX);

   always_ff @(posedge clock) begin
      if (reset) begin
         network_ff <= RESET_NETWORK;
         prefix_ff  <= RESET_PREFIX;
      end else if (csr_write) begin
         if (csr_if.index == CSR_NETWORK) begin
            network_ff <= csr_if.data;
         end
         if (csr_if.index == CSR_PREFIX) begin
            prefix_ff <= csr_if.data[PREFIX_W-1:0];
         end
      end
   end

   assign host_bits = HOST_W'(32) - HOST_W'(prefix_ff);
   assign host_mask = ~({ADDR_W{1'b1}} << host_bits);

   always_comb begin
      cfg.host_bits = host_bits;
      cfg.host_mask = host_mask;
      cfg.network   = network_ff;
      cfg.ok        = (int'(host_bits) >= 2) && (int'(host_bits) <= MAX_HOST_BITS) &&
                      ((network_ff & host_mask) == '0);
   end

   ipta_sequencer #(
      .MAX_HOST_BITS(MAX_HOST_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .rebuild     (rebuild),
      .cfg         (cfg),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_kind    (req_if.kind),
      .req_address (req_if.address),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_status  (rsp_if.status),
      .rsp_granted (rsp_if.granted_address),
      .rsp_count   (rsp_if.free_count),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   ipta_node_ram #(
      .AW(NW)
   ) u_ram (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

endmodule

`default_nettype wire

// ----- rtl/ipta_checker.sv -----
// ----------------------------------------------------------------------------
// IP pool trie allocator checker
// Port-level properties of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ipta_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [ipta_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [ipta_pkg::ADDR_W-1:0]   rsp_granted,
   input wire logic [ipta_pkg::COUNT_W-1:0]  rsp_count
);

   import ipta_pkg::*;

   a_no_accept_with_pending: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !rsp_valid)
      else $error("item accepted while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after an accepted item");

   a_one_response: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("second response without a new item");

   a_grant_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_granted == '0))
      else $error("granted address on a failed item");

   a_config_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_CONFIG) |-> (rsp_count == '0))
      else $error("free count nonzero under config error");

endmodule

bind ip_pool_trie_allocator ipta_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_status  (rsp_if.status),
   .rsp_granted (rsp_if.granted_address),
   .rsp_count   (rsp_if.free_count)
);

`default_nettype wire

// ----- tb/sv/ip_pool_trie_allocator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IP pool trie allocator testbench
// Drives allocate and release items through the request channel, rewrites
// the pool configuration between phases and checks every reply against a
// trie of full bits kept alongside the block, under several idle patterns.
// ----------------------------------------------------------------------------

module ip_pool_trie_allocator_tb;
   import ipta_pkg::*;

   localparam int TREE_DEPTH    = 8;
   localparam int NODE_SLOTS    = 1 << (TREE_DEPTH + 1);
   localparam int SETTLE_CYCLES = NODE_SLOTS + 3 * (2 * TREE_DEPTH + 1) + 32;
   localparam int TAIL_CYCLES   = 4 * TREE_DEPTH + 8;
   localparam longint RUN_LIMIT_NS = 2_000_000;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef struct {
      status_type         status;
      logic [ADDR_W-1:0]  granted;
      logic [COUNT_W-1:0] free_count;
   } reply_type;

   logic clock;
   logic reset;

   ipta_req_if req_ch ();
   ipta_rsp_if rsp_ch ();
   ipta_csr_if csr_ch ();

   ip_pool_trie_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   reply_type         pending_replies[$];
   logic [ADDR_W-1:0] leased[$];
   int                errors        = 0;
   int                send_idle_pct = 0;
   int                stall_pct     = 0;
   int                hold_left     = 0;

   bit                  subtree_full[NODE_SLOTS];
   logic [ADDR_W-1:0]   pool_net;
   logic [ADDR_W-1:0]   host_mask;
   logic [PREFIX_W-1:0] pool_prefix;
   int unsigned         host_bits;
   int unsigned         free_left;
   bit                  pool_ok;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void refresh_ancestors(int unsigned node);
      while (node > 1) begin
         node = node >> 1;
         subtree_full[node] = subtree_full[2 * node] & subtree_full[2 * node + 1];
      end
   endfunction

   function automatic logic [ADDR_W-1:0] claim_address(logic [ADDR_W-1:0] wanted);
      int unsigned       node = 1;
      int unsigned       lvl  = host_bits;
      logic [ADDR_W-1:0] path = '0;
      logic              b;
      while (lvl > 0) begin
         lvl--;
         b = wanted[lvl];
         if (subtree_full[2 * node + b]) begin
            b = ~b;
         end
         path[lvl] = b;
         node = 2 * node + b;
      end
      subtree_full[node] = 1'b1;
      refresh_ancestors(node);
      if (free_left > 0) begin
         free_left--;
      end
      return pool_net | path;
   endfunction

   function automatic void rebuild_pool();
      int unsigned p = pool_prefix;
      foreach (subtree_full[i]) subtree_full[i] = 1'b0;
      host_bits = 32 - p;
      pool_ok   = 1'b0;
      host_mask = '0;
      free_left = 0;
      if (host_bits < 2 || host_bits > TREE_DEPTH) begin
         return;
      end
      host_mask = (32'd1 << host_bits) - 32'd1;
      if ((pool_net & host_mask) != '0) begin
         return;
      end
      pool_ok   = 1'b1;
      free_left = 1 << host_bits;
      void'(claim_address(pool_net));
      void'(claim_address(pool_net + 32'd1));
      void'(claim_address(pool_net | host_mask));
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
      case (idx)
         CSR_NETWORK: begin
            pool_net = val;
         end
         CSR_PREFIX: begin
            pool_prefix = val[PREFIX_W-1:0];
         end
         default: begin
            return;
         end
      endcase
      rebuild_pool();
      leased.delete();
   endfunction

   function automatic reply_type pool_answer(logic kind, logic [ADDR_W-1:0] addr);
      reply_type   r;
      int unsigned leaf;
      int unsigned n;
      r.status  = STATUS_OK;
      r.granted = '0;
      if (!pool_ok) begin
         r.status = STATUS_CONFIG;
      end else if (kind == KIND_ALLOC) begin
         if ((addr & ~host_mask) != pool_net) begin
            r.status = STATUS_RANGE;
         end else if (subtree_full[1]) begin
            r.status = STATUS_FULL;
         end else begin
            r.granted = claim_address(addr);
         end
      end else if ((addr & ~host_mask) != pool_net || addr == pool_net ||
                   addr == pool_net + 32'd1 || addr == (pool_net | host_mask)) begin
         r.status = STATUS_RANGE;
      end else begin
         leaf = (1 << host_bits) | (addr & host_mask);
         if (!subtree_full[leaf]) begin
            r.status = STATUS_DOUBLE;
         end else begin
            for (n = leaf; n >= 1; n = n >> 1) subtree_full[n] = 1'b0;
            free_left++;
         end
      end
      r.free_count = free_left[COUNT_W-1:0];
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] pool_address();
      int unsigned pick = $urandom_range(99);
      if (pick < 72) begin
         return pool_net | ($urandom & host_mask);
      end
      if (pick < 82) begin
         case (pick % 3)
            0: return pool_net;
            1: return pool_net + 32'd1;
            default: return pool_net | host_mask;
         endcase
      end
      if (pick < 90) begin
         return pool_net ^ (32'd1 << $urandom_range(31));
      end
      return $urandom;
   endfunction

   function automatic logic [ADDR_W-1:0] release_address();
      int unsigned slot;
      if (leased.size() > 0 && $urandom_range(99) < 70) begin
         slot = $urandom_range(leased.size() - 1);
         release_address = leased[slot];
         leased.delete(slot);
      end else begin
         release_address = pool_address();
      end
   endfunction

   function automatic void check_field(string field, logic [ADDR_W-1:0] want,
                                       logic [ADDR_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      end
   endfunction

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected reply, expected none actual status %0d granted %h count %0d",
                     $time, rsp_ch.status, rsp_ch.granted_address, rsp_ch.free_count);
         end else begin
            want = pending_replies.pop_front();
            check_field("status", want.status, rsp_ch.status);
            check_field("granted_address", want.granted, rsp_ch.granted_address);
            check_field("free_count", want.free_count, rsp_ch.free_count);
         end
      end
   end

   task automatic send_item(input logic kind, input logic [ADDR_W-1:0] addr);
      reply_type r;
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= kind;
      req_ch.address <= addr;
      do @(posedge clock); while (!req_ch.ready);
      r = pool_answer(kind, addr);
      pending_replies.push_back(r);
      if (kind == KIND_ALLOC && r.status == STATUS_OK) begin
         leased.push_back(r.granted);
      end
   endtask

   task automatic drain_replies();
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [ADDR_W-1:0] val);
      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      apply_register(idx, val);
   endtask

   task automatic random_burst(input int count, input int alloc_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < alloc_pct) begin
            send_item(KIND_ALLOC, pool_address());
         end else begin
            send_item(KIND_FREE, release_address());
         end
      end
   endtask

   task automatic pick_random_pool();
      int unsigned         pick = $urandom_range(99);
      logic [PREFIX_W-1:0] pfx;
      logic [ADDR_W-1:0]   net;
      pfx = ($urandom_range(99) < 20) ? 5'd24 : 5'($urandom_range(30, 25));
      net = $urandom;
      if (pick < 4) begin
         net = '0;
      end else if (pick < 8) begin
         net = '1;
      end
      if (pick < 86) begin
         net = net & ~((32'd1 << (32 - pfx)) - 32'd1);
      end else if (pick < 93) begin
         pfx = pick[0] ? 5'd31 : 5'($urandom_range(23, 0));
      end
      write_register(CSR_PREFIX, ADDR_W'(pfx));
      write_register(CSR_NETWORK, net);
   endtask

   task automatic test_default_pool();
      logic [ADDR_W-1:0] base = RESET_NETWORK;
      send_item(KIND_ALLOC, base);
      send_item(KIND_ALLOC, base | 32'hFF);
      send_item(KIND_ALLOC, base | 32'h80);
      send_item(KIND_ALLOC, base | 32'h80);
      send_item(KIND_FREE, base | 32'h80);
      send_item(KIND_FREE, base | 32'h80);
      send_item(KIND_FREE, base);
      send_item(KIND_FREE, base + 32'd1);
      send_item(KIND_FREE, base | 32'hFF);
      send_item(KIND_ALLOC, 32'h0000_0000);
      send_item(KIND_ALLOC, 32'hFFFF_FFFF);
      send_item(KIND_FREE, 32'hFFFF_FFFF);
      send_item(KIND_FREE, 32'h0000_0000);
      send_item(KIND_ALLOC, base | 32'h55);
      send_item(KIND_FREE, base | 32'hAA);
   endtask

   task automatic test_config_errors();
      write_register(CSR_PREFIX, 32'd31);
      send_item(KIND_ALLOC, RESET_NETWORK | 32'h5);
      send_item(KIND_FREE, RESET_NETWORK | 32'h5);
      write_register(CSR_PREFIX, 32'd23);
      send_item(KIND_ALLOC, RESET_NETWORK | 32'h9);
      write_register(CSR_PREFIX, 32'd0);
      send_item(KIND_FREE, RESET_NETWORK | 32'h9);
      write_register(CSR_PREFIX, 32'd30);
      write_register(CSR_NETWORK, RESET_NETWORK | 32'h1);
      send_item(KIND_ALLOC, RESET_NETWORK);
      write_register(CSR_NETWORK, RESET_NETWORK);
      write_register(CSR_PREFIX, 32'hFFFF_FFF8);
      write_register(CSR_SPARE_LO, $urandom);
      write_register(CSR_SPARE_HI, $urandom);
      send_item(KIND_ALLOC, RESET_NETWORK | 32'h10);
   endtask

   task automatic test_small_pool_full();
      write_register(CSR_NETWORK, 32'hFFFF_FFFC);
      write_register(CSR_PREFIX, 32'd30);
      send_item(KIND_ALLOC, 32'hFFFF_FFFC);
      send_item(KIND_ALLOC, 32'hFFFF_FFFE);
      send_item(KIND_FREE, 32'hFFFF_FFFE);
      send_item(KIND_ALLOC, 32'hFFFF_FFFF);
   endtask

   task automatic test_large_pool_fill();
      write_register(CSR_PREFIX, 32'd24);
      write_register(CSR_NETWORK, $urandom & 32'hFFFF_FF00);
      for (int i = 0; i < 256; i++) begin
         send_item(KIND_ALLOC, pool_net | ($urandom & host_mask));
      end
      random_burst(20, 50);
   endtask

   task automatic test_receiver_hold();
      send_idle_pct = 0;
      stall_pct     = 0;
      pick_random_pool();
      hold_left = 400;
      random_burst(30, 60);
   endtask

   task automatic test_sender_drain();
      send_idle_pct = 29;
      stall_pct     = 29;
      random_burst(15, 60);
      drain_replies();
      random_burst(15, 40);
   endtask

   task automatic test_random_traffic();
      int idle_mix[4]  = '{0, 71, 0, 29};
      int stall_mix[4] = '{0, 0, 71, 29};
      for (int m = 0; m < 4; m++) begin
         send_idle_pct = idle_mix[m];
         stall_pct     = stall_mix[m];
         for (int k = 0; k < 4; k++) begin
            pick_random_pool();
            random_burst(45, k[0] ? 45 : 70);
         end
      end
      test_large_pool_fill();
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.kind    = KIND_ALLOC;
      req_ch.address = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = CSR_NETWORK;
      csr_ch.data    = '0;
      pool_net       = RESET_NETWORK;
      pool_prefix    = RESET_PREFIX;
      rebuild_pool();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_default_pool();
      test_config_errors();
      test_small_pool_full();
      test_receiver_hold();
      test_sender_drain();
      test_random_traffic();

      drain_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("ip_pool_trie_allocator regression: pass");
      end else begin
         $display("ip_pool_trie_allocator regression: fail");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("ip_pool_trie_allocator regression: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ipta_pkg.sv
rtl/ipta_if.sv
rtl/ipta_node_ram.sv
rtl/ipta_sequencer.sv
rtl/ip_pool_trie_allocator.sv
rtl/ipta_checker.sv
tb/sv/ip_pool_trie_allocator_tb.sv
